// File: sv/rgbca_pkg.sv
// Shared constants, types and factor tables for the RGB color adjust block.
package rgbca_pkg;

  // Fixed-point fraction bits of all adjustment factors
  localparam int FRAC_BITS = 16;

  // Cycles from the accepting edge to the edge that takes the result
  localparam int LATENCY = 7;

  // Factor word: contrast gain stays below 8.0, so three integer bits plus sign
  localparam int FACT_W = FRAC_BITS + 4;
  // Channel operand (9-bit signed) times factor
  localparam int PROD_W = FACT_W + 9;
  // Contrast sum carries one extra bit for the mid-grey bias
  localparam int CSUM_W = PROD_W + 1;
  // Width of a product once the fraction is shifted out
  localparam int SH_W   = PROD_W - FRAC_BITS;
  // Working width of a channel value before clamping
  localparam int V_W    = 14;
  // Brightness offset, range -327..323
  localparam int BX_W   = 10;

  // Vibrance: q = floor(p * 2^FRAC_BITS / 38250), p below 2^16
  localparam int Q_W     = FRAC_BITS + 1;
  localparam int VIB_SH  = 31;
  localparam int RECIP_W = FRAC_BITS + 16;
  localparam int REM_W   = FRAC_BITS + 17;
  localparam logic [15:0] VIB_DEN = 16'd38250;
  localparam logic [RECIP_W-1:0] VIB_RECIP =
    RECIP_W'((64'd1 << (FRAC_BITS + VIB_SH)) / 64'd38250);

  // Greyscale: floor(n / 100) for n below 2^15 as (n * ceil(2^22/100)) >> 22
  localparam int GREY_SH = 22;
  localparam logic [15:0] GREY_RECIP = 16'(((1 << GREY_SH) + 99) / 100);

  // Contrast bias 255 * 2^FRAC_BITS and rounding masks
  localparam logic signed [CSUM_W-1:0] CON_BIAS  = CSUM_W'(64'sd255 <<< FRAC_BITS);
  localparam logic signed [PROD_W-1:0] FRAC_MASK = PROD_W'((64'sd1 <<< FRAC_BITS) - 1);
  localparam logic signed [CSUM_W-1:0] CON_MASK  =
    CSUM_W'((64'sd1 <<< (FRAC_BITS + 1)) - 1);

  // Mode register codes
  localparam logic [2:0] MODE_BRIGHT   = 3'd0;
  localparam logic [2:0] MODE_SAT      = 3'd1;
  localparam logic [2:0] MODE_VIBRANCE = 3'd2;
  localparam logic [2:0] MODE_GREY     = 3'd3;
  localparam logic [2:0] MODE_CONTRAST = 3'd4;
  localparam logic [2:0] MODE_COLOR    = 3'd5;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMOUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TGREEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TBLUE  = 3'd4;

  // Per-channel operation
  typedef enum logic [2:0] {
    OP_PASS,
    OP_BRIGHT,
    OP_PULL,
    OP_GREY,
    OP_CONTRAST,
    OP_COLOR
  } op_t;

  // Control beat handed to each channel slice
  typedef struct packed {
    op_t                      op;
    logic signed [FACT_W-1:0] fact;
    logic signed [BX_W-1:0]   bright;
    logic [7:0]               grey;
  } chan_ctl_t;

  typedef logic signed [BX_W-1:0]   bx_tbl_t   [256];
  typedef logic signed [FACT_W-1:0] fact_tbl_t [256];

  // floor(255 * a / 100) for every 8-bit amount
  function automatic bx_tbl_t build_bright();
    bx_tbl_t tbl;
    longint  a;
    for (int i = 0; i < 256; i++) begin
      a = (i >= 128) ? longint'(i) - 256 : longint'(i);
      if (a >= 0) tbl[i] = BX_W'((255 * a) / 100);
      else        tbl[i] = BX_W'(-((255 * (-a) + 99) / 100));
    end
    return tbl;
  endfunction

  // trunc0(-a * 2^F / 100); colorize uses its negative
  function automatic fact_tbl_t build_sat();
    fact_tbl_t tbl;
    longint    a;
    longint    v;
    for (int i = 0; i < 256; i++) begin
      a = (i >= 128) ? longint'(i) - 256 : longint'(i);
      v = -a * (longint'(1) << FRAC_BITS);
      if (v < 0) tbl[i] = FACT_W'(-((-v) / 100));
      else       tbl[i] = FACT_W'(v / 100);
    end
    return tbl;
  endfunction

  // (a + 100)^2 * 2^F / 10000, never negative
  function automatic fact_tbl_t build_contrast();
    fact_tbl_t tbl;
    longint    a;
    for (int i = 0; i < 256; i++) begin
      a = (i >= 128) ? longint'(i) - 256 : longint'(i);
      tbl[i] = FACT_W'(((a + 100) * (a + 100) * (longint'(1) << FRAC_BITS)) / 10000);
    end
    return tbl;
  endfunction

  localparam bx_tbl_t   BRIGHT_TBL = build_bright();
  localparam fact_tbl_t SAT_TBL    = build_sat();
  localparam fact_tbl_t CON_TBL    = build_contrast();

endpackage

// File: sv/rgbca_chan.sv
// One color channel: factor multiply, then rounding, offset and clamp.
module rgbca_chan (
  input  logic                 clk,
  input  rgbca_pkg::chan_ctl_t ctl,
  input  logic [7:0]           c,
  input  logic [7:0]           m,
  input  logic [7:0]           t,
  output logic [7:0]           res
);

  logic signed [8:0]                   opnd;
  logic signed [9:0]                   dbl;
  logic signed [rgbca_pkg::PROD_W-1:0] prod_next;

  logic signed [rgbca_pkg::PROD_W-1:0] prod;
  rgbca_pkg::op_t                      op;
  logic [7:0]                          cval;
  logic signed [rgbca_pkg::BX_W-1:0]   bright;
  logic [7:0]                          grey;

  logic signed [rgbca_pkg::PROD_W-1:0] prod_rnd;
  logic signed [rgbca_pkg::CSUM_W-1:0] csum;
  logic signed [rgbca_pkg::CSUM_W-1:0] csum_rnd;
  logic signed [rgbca_pkg::SH_W-1:0]   floor_sh;
  logic signed [rgbca_pkg::SH_W-1:0]   trunc_sh;
  logic signed [rgbca_pkg::SH_W-1:0]   con_sh;
  logic signed [rgbca_pkg::V_W-1:0]    c_ext;
  logic signed [rgbca_pkg::V_W-1:0]    v;

  // Multiplier operand per operation
  always_comb begin
    dbl = $signed({1'b0, c, 1'b0}) - 10'sd255;
    case (ctl.op)
      rgbca_pkg::OP_PULL:     opnd = $signed({1'b0, m}) - $signed({1'b0, c});
      rgbca_pkg::OP_CONTRAST: opnd = dbl[8:0];
      rgbca_pkg::OP_COLOR:    opnd = $signed({1'b0, c}) - $signed({1'b0, t});
      default:                opnd = 9'sd0;
    endcase
    prod_next = opnd * ctl.fact;
  end

  // Product stage
  always_ff @(posedge clk) begin
    prod   <= prod_next;
    op     <= ctl.op;
    cval   <= c;
    bright <= ctl.bright;
    grey   <= ctl.grey;
  end

  // Shift out the fraction: floor for pull, toward zero for colorize and contrast
  always_comb begin
    floor_sh = prod[rgbca_pkg::PROD_W-1:rgbca_pkg::FRAC_BITS];
    prod_rnd = prod + (prod[rgbca_pkg::PROD_W-1] ? rgbca_pkg::FRAC_MASK
                                                  : {rgbca_pkg::PROD_W{1'b0}});
    trunc_sh = prod_rnd[rgbca_pkg::PROD_W-1:rgbca_pkg::FRAC_BITS];
    csum     = rgbca_pkg::CSUM_W'(prod) + rgbca_pkg::CON_BIAS;
    csum_rnd = csum + (csum[rgbca_pkg::CSUM_W-1] ? rgbca_pkg::CON_MASK
                                                  : {rgbca_pkg::CSUM_W{1'b0}});
    con_sh   = csum_rnd[rgbca_pkg::CSUM_W-1:rgbca_pkg::FRAC_BITS+1];
    c_ext    = $signed(rgbca_pkg::V_W'(cval));
    case (op)
      rgbca_pkg::OP_BRIGHT:   v = c_ext + rgbca_pkg::V_W'(bright);
      rgbca_pkg::OP_PULL:     v = c_ext + rgbca_pkg::V_W'(floor_sh);
      rgbca_pkg::OP_COLOR:    v = c_ext + rgbca_pkg::V_W'(trunc_sh);
      rgbca_pkg::OP_CONTRAST: v = rgbca_pkg::V_W'(con_sh);
      rgbca_pkg::OP_GREY:     v = $signed(rgbca_pkg::V_W'(grey));
      default:                v = c_ext;
    endcase
  end

  // Clamp to 0..255 into the output register
  always_ff @(posedge clk) begin
    if (v < 0) begin
      res <= 8'd0;
    end else if (v > 255) begin
      res <= 8'd255;
    end else begin
      res <= v[7:0];
    end
  end

endmodule

// File: sv/rgb_color_adjust.sv
// Top level of the RGB color adjust pipeline.
//
// Pixel channel: a pixel beat is taken on in_red/in_green/in_blue at every
// clock edge where start is high and busy is low. busy is always low, so a
// pixel may enter on every cycle.
// Result channel: done is high for one cycle with the adjusted pixel on
// out_red/out_green/out_blue; the receiver cannot stall, nothing is held.
// Throughput is one pixel per clock since every stage takes a new beat
// each cycle. The seven register stages are input capture, max/sums,
// vibrance product, reciprocal multiply, remainder fix, channel multiply,
// and round and clamp.
// Configuration: cfg_valid/cfg_ready write cfg_data into the register at
// cfg_index (0 mode, 1 amount, 2..4 colorize target); cfg_ready is always
// high and indexes above four are dropped. Amount-derived factors are looked
// up on the write, so registers must be written while no pixel is in flight.
// Reset (rst, synchronous) empties the pipeline and sets mode brightness,
// amount zero and target blue.
module rgb_color_adjust (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_blue,
  output logic                            done,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rgbca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] m;
  } pix_t;

  // Configuration registers
  logic [2:0]                          mode;
  logic signed [8:0]                   neg_a;
  logic signed [rgbca_pkg::BX_W-1:0]   bright_x;
  logic signed [rgbca_pkg::FACT_W-1:0] sat_f;
  logic signed [rgbca_pkg::FACT_W-1:0] con_x;
  logic [7:0]                          target_red;
  logic [7:0]                          target_green;
  logic [7:0]                          target_blue;

  // Pipeline registers
  logic [5:0]                          vld;
  pix_t                                pix0, pix1, pix2, pix3, pix4;
  logic [9:0]                          d1;
  logic [14:0]                         gsum1;
  logic [15:0]                         pmag2, pmag3;
  logic                                pneg2, pneg3;
  logic [7:0]                          grey2, grey3;
  logic [rgbca_pkg::Q_W-1:0]           q3;
  rgbca_pkg::chan_ctl_t                ctl4;

  // Stage logic
  logic [7:0]                          max_rg;
  logic [7:0]                          max_rgb;
  logic [9:0]                          sum;
  logic [9:0]                          m3;
  logic signed [19:0]                  p;
  logic signed [19:0]                  p_abs;
  logic [30:0]                         gprod;
  logic [15+rgbca_pkg::RECIP_W:0]      qprod;
  logic [rgbca_pkg::REM_W-1:0]         num;
  logic [rgbca_pkg::REM_W-1:0]         qd;
  logic [rgbca_pkg::REM_W-1:0]         rem;
  logic [rgbca_pkg::Q_W-1:0]           q_fix;
  logic signed [rgbca_pkg::FACT_W-1:0] vib_pos;
  logic signed [rgbca_pkg::FACT_W-1:0] vib_f;
  rgbca_pkg::chan_ctl_t                ctl_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration writes; amount factors come from the constant tables
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= rgbca_pkg::MODE_BRIGHT;
      neg_a        <= 9'sd0;
      bright_x     <= rgbca_pkg::BRIGHT_TBL[0];
      sat_f        <= rgbca_pkg::SAT_TBL[0];
      con_x        <= rgbca_pkg::CON_TBL[0];
      target_red   <= 8'd0;
      target_green <= 8'd0;
      target_blue  <= 8'd255;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rgbca_pkg::REG_MODE: begin
          mode <= cfg_data[2:0];
        end
        rgbca_pkg::REG_AMOUNT: begin
          neg_a    <= 9'sd0 - $signed({cfg_data[7], cfg_data});
          bright_x <= rgbca_pkg::BRIGHT_TBL[cfg_data];
          sat_f    <= rgbca_pkg::SAT_TBL[cfg_data];
          con_x    <= rgbca_pkg::CON_TBL[cfg_data];
        end
        rgbca_pkg::REG_TRED:   target_red   <= cfg_data;
        rgbca_pkg::REG_TGREEN: target_green <= cfg_data;
        rgbca_pkg::REG_TBLUE:  target_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits travel with the beats
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[4:0], start};
      done <= vld[5];
    end
  end

  // Stage 1: channel max, saturation spread and luma sum
  always_comb begin
    max_rg  = (pix0.r > pix0.g) ? pix0.r : pix0.g;
    max_rgb = (pix0.b > max_rg) ? pix0.b : max_rg;
    sum     = 10'(pix0.r) + 10'(pix0.g) + 10'(pix0.b);
    m3      = {1'b0, max_rgb, 1'b0} + 10'(max_rgb);
  end

  // Stage 2: vibrance product and luma divide by 100
  always_comb begin
    p     = $signed({1'b0, d1}) * neg_a;
    p_abs = p[19] ? (20'sd0 - p) : p;
    gprod = 31'(gsum1) * 31'(rgbca_pkg::GREY_RECIP);
  end

  // Stage 3: reciprocal estimate of p * 2^F / 38250
  always_comb begin
    qprod = pmag2 * rgbca_pkg::VIB_RECIP;
  end

  // Stage 4: one-step correction of the estimate, then per-mode control
  always_comb begin
    num     = rgbca_pkg::REM_W'({pmag3, {rgbca_pkg::FRAC_BITS{1'b0}}});
    qd      = rgbca_pkg::REM_W'(q3) * rgbca_pkg::REM_W'(rgbca_pkg::VIB_DEN);
    rem     = num - qd;
    q_fix   = q3 + rgbca_pkg::Q_W'(rem >= rgbca_pkg::REM_W'(rgbca_pkg::VIB_DEN));
    vib_pos = $signed(rgbca_pkg::FACT_W'(q_fix));
    vib_f   = pneg3 ? -vib_pos : vib_pos;

    ctl_next.bright = bright_x;
    ctl_next.grey   = grey3;
    // colorize factor trunc0(a*S/100) is the negated saturation factor
    unique case (mode)
      rgbca_pkg::MODE_BRIGHT: begin
        ctl_next.op   = rgbca_pkg::OP_BRIGHT;
        ctl_next.fact = '0;
      end
      rgbca_pkg::MODE_SAT: begin
        ctl_next.op   = rgbca_pkg::OP_PULL;
        ctl_next.fact = sat_f;
      end
      rgbca_pkg::MODE_VIBRANCE: begin
        ctl_next.op   = rgbca_pkg::OP_PULL;
        ctl_next.fact = vib_f;
      end
      rgbca_pkg::MODE_GREY: begin
        ctl_next.op   = rgbca_pkg::OP_GREY;
        ctl_next.fact = '0;
      end
      rgbca_pkg::MODE_CONTRAST: begin
        ctl_next.op   = rgbca_pkg::OP_CONTRAST;
        ctl_next.fact = con_x;
      end
      rgbca_pkg::MODE_COLOR: begin
        ctl_next.op   = rgbca_pkg::OP_COLOR;
        ctl_next.fact = sat_f;
      end
      default: begin
        ctl_next.op   = rgbca_pkg::OP_PASS;
        ctl_next.fact = '0;
      end
    endcase
  end

  // Payload registers, stages 0 to 4
  always_ff @(posedge clk) begin
    pix0.r <= in_red;
    pix0.g <= in_green;
    pix0.b <= in_blue;
    pix0.m <= 8'd0;

    pix1   <= '{r: pix0.r, g: pix0.g, b: pix0.b, m: max_rgb};
    d1     <= m3 - sum;
    gsum1  <= 15'(pix0.r) * 15'd30 + 15'(pix0.g) * 15'd59 + 15'(pix0.b) * 15'd11;

    pix2   <= pix1;
    pmag2  <= p_abs[15:0];
    pneg2  <= p[19];
    grey2  <= gprod[rgbca_pkg::GREY_SH +: 8];

    pix3   <= pix2;
    pmag3  <= pmag2;
    pneg3  <= pneg2;
    grey3  <= grey2;
    q3     <= qprod[rgbca_pkg::VIB_SH +: rgbca_pkg::Q_W];

    pix4   <= pix3;
    ctl4   <= ctl_next;
  end

  // Stages 5 and 6, one slice per channel
  rgbca_chan u_red (
    .clk (clk),
    .ctl (ctl4),
    .c   (pix4.r),
    .m   (pix4.m),
    .t   (target_red),
    .res (out_red)
  );

  rgbca_chan u_green (
    .clk (clk),
    .ctl (ctl4),
    .c   (pix4.g),
    .m   (pix4.m),
    .t   (target_green),
    .res (out_green)
  );

  rgbca_chan u_blue (
    .clk (clk),
    .ctl (ctl4),
    .c   (pix4.b),
    .m   (pix4.m),
    .t   (target_blue),
    .res (out_blue)
  );

endmodule

// File: sv/rgbca_checker.sv
// Port-level checks for the RGB color adjust block, bound to the top level.
module rgbca_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic [7:0]                      out_red,
  input logic [7:0]                      out_green,
  input logic [7:0]                      out_blue,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [rgbca_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [7:0]                      cfg_data
);

  logic [2:0] mode_sh;

  // Shadow of the mode register as seen on the configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_sh <= rgbca_pkg::MODE_BRIGHT;
    end else if (cfg_valid && cfg_ready && cfg_index == rgbca_pkg::REG_MODE) begin
      mode_sh <= cfg_data[2:0];
    end
  end

  // Every accepted pixel comes out after the fixed latency
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(rgbca_pkg::LATENCY) done)
    else $error("accepted pixel produced no result at fixed latency");

  // No result without a pixel accepted at the fixed latency before it
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, rgbca_pkg::LATENCY))
    else $error("result beat without a matching accepted pixel");

  // Reset empties the pipeline
  assert property (@(posedge clk)
    rst |=> !done)
    else $error("result beat right after reset");

  // Greyscale gives equal channels
  assert property (@(posedge clk) disable iff (rst)
    (done && mode_sh == rgbca_pkg::MODE_GREY) |->
      (out_red == out_green && out_green == out_blue))
    else $error("greyscale result with unequal channels");

endmodule

bind rgb_color_adjust rgbca_checker u_rgbca_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);

// File: tb/sv/rgb_color_adjust_check.sv
// Checker for rgb_color_adjust: mirrors the registers, predicts each adjusted pixel, compares.
`timescale 1ns / 100ps
module rgb_color_adjust_check
  import rgbca_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  input  logic                 done,
  input  logic [7:0]           out_red,
  input  logic [7:0]           out_green,
  input  logic [7:0]           out_blue,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   fail_count,
  output int                   in_flight
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // 1.0 in the block's fixed-point format
  localparam longint ONE = longint'(1) << FRAC_BITS;

  // Local copy of the register file
  logic [2:0]        mode_q     = MODE_BRIGHT;
  logic signed [7:0] amount_q   = '0;
  logic [7:0]        tgt_red_q  = 8'd0;
  logic [7:0]        tgt_grn_q  = 8'd0;
  logic [7:0]        tgt_blu_q  = 8'd255;

  pixel_t pending_pixels[$];
  int     errors = 0;

  function automatic logic [7:0] clamp_byte(longint v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  // Arithmetic shift that rounds toward zero instead of down
  function automatic longint shift_trunc(longint v, int s);
    return (v < 0) ? -((-v) >>> s) : (v >>> s);
  endfunction

  // Adjusted pixel under the current register settings
  function automatic pixel_t adjust_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
    longint     ch[3];
    longint     tgt[3];
    logic [7:0] res[3];
    longint     a;
    longint     m;
    longint     f;
    longint     x;
    longint     y;
    ch[0]  = r8;
    ch[1]  = g8;
    ch[2]  = b8;
    tgt[0] = tgt_red_q;
    tgt[1] = tgt_grn_q;
    tgt[2] = tgt_blu_q;
    a = amount_q;
    f = 0;
    x = 0;
    m = ch[0];
    if (ch[1] > m) m = ch[1];
    if (ch[2] > m) m = ch[2];
    y = (30 * ch[0] + 59 * ch[1] + 11 * ch[2]) / 100;

    // per-pixel factor; signed division truncates toward zero
    case (mode_q)
      MODE_BRIGHT:   x = (a >= 0) ? (255 * a) / 100 : -((255 * (-a) + 99) / 100);
      MODE_SAT:      f = (-a * ONE) / 100;
      MODE_VIBRANCE: f = ((3 * m - (ch[0] + ch[1] + ch[2])) * (-a) * ONE) / 38250;
      MODE_CONTRAST: x = ((a + 100) * (a + 100) * ONE) / 10000;
      MODE_COLOR:    f = (a * ONE) / 100;
      default: ;
    endcase

    for (int i = 0; i < 3; i++) begin
      case (mode_q)
        MODE_BRIGHT: res[i] = clamp_byte(ch[i] + x);
        // max channel stays put; others move along (max - c), product floored
        MODE_SAT, MODE_VIBRANCE: begin
          res[i] = (ch[i] == m) ? 8'(ch[i])
                                : clamp_byte(ch[i] + (((m - ch[i]) * f) >>> FRAC_BITS));
        end
        MODE_GREY: res[i] = clamp_byte(y);
        // (c - 127.5) * x + 127.5, done in doubled units
        MODE_CONTRAST: begin
          res[i] = clamp_byte(shift_trunc((2 * ch[i] - 255) * x + 255 * ONE, FRAC_BITS + 1));
        end
        MODE_COLOR: res[i] = clamp_byte(ch[i] - shift_trunc((ch[i] - tgt[i]) * f, FRAC_BITS));
        default: res[i] = 8'(ch[i]);
      endcase
    end
    return {res[0], res[1], res[2]};
  endfunction

  task automatic check_channel(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Result beats are checked before this edge's pixel and register beats are applied
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      mode_q    = MODE_BRIGHT;
      amount_q  = '0;
      tgt_red_q = 8'd0;
      tgt_grn_q = 8'd0;
      tgt_blu_q = 8'd255;
      pending_pixels.delete();
    end else begin
      if (done === 1'b1) begin
        if (pending_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat: expected none, actual %0d/%0d/%0d",
                   $time, out_red, out_green, out_blue);
        end else begin
          want = pending_pixels.pop_front();
          check_channel("out_red", want.red, out_red);
          check_channel("out_green", want.green, out_green);
          check_channel("out_blue", want.blue, out_blue);
        end
      end

      if (start && !busy)
        pending_pixels.insert(pending_pixels.size(), adjust_pixel(in_red, in_green, in_blue));

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:   mode_q    = cfg_data[2:0];
          REG_AMOUNT: amount_q  = cfg_data;
          REG_TRED:   tgt_red_q = cfg_data;
          REG_TGREEN: tgt_grn_q = cfg_data;
          REG_TBLUE:  tgt_blu_q = cfg_data;
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    in_flight  <= pending_pixels.size();
  end

endmodule

// File: tb/sv/rgb_color_adjust_test.sv
// Testbench top for rgb_color_adjust: clock, reset, pixel and register stimulus, verdict.
`timescale 1ns / 100ps
module rgb_color_adjust_test;
  import rgbca_pkg::*;

  localparam int PIPE_DEPTH   = 7;
  localparam int PIXEL_BUDGET = 1650;

  // Mode codes the block does not decode; the pixel passes through
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  // Highest register index; everything above REG_TBLUE is dropped
  localparam logic [CFG_IDX_W-1:0] REG_LAST_IDX = 3'd7;

  typedef enum {IDLE_NONE, IDLE_ANY, IDLE_SPARSE} idle_style_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic [7:0]           in_red    = 8'd0;
  logic [7:0]           in_green  = 8'd0;
  logic [7:0]           in_blue   = 8'd0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MODE;
  logic [7:0]           cfg_data  = 8'd0;
  logic                 busy;
  logic                 done;
  logic                 cfg_ready;
  logic [7:0]           out_red;
  logic [7:0]           out_green;
  logic [7:0]           out_blue;
  int                   fail_count;
  int                   in_flight;
  int                   pixels_sent = 0;
  idle_style_t          idle_style  = IDLE_NONE;

  rgb_color_adjust u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .done      (done),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rgb_color_adjust_check u_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .done       (done),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .in_flight  (in_flight)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hang guard
  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d results still outstanding", $time, in_flight);
    $display("** rgb_color_adjust: FAILED **");
    $finish;
  end

  // Idle cycles before the next beat, by the current phase's style
  function automatic int draw_gap();
    case (idle_style)
      IDLE_NONE: return 0;
      IDLE_ANY:  return $urandom_range(0, 16);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  // One pixel beat; start stays high when the next beat follows at once
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (busy);
    pixels_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Drain the pipeline: start and cfg_valid low until all results are in, then idle
  task automatic settle();
    start     <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // New register setting; now and then a write to an undecoded index follows
  task automatic apply_setting(input logic [7:0] mode_byte, input logic [7:0] amount,
                               input logic [7:0] tr, input logic [7:0] tg,
                               input logic [7:0] tb);
    settle();
    write_reg(REG_MODE, mode_byte);
    write_reg(REG_AMOUNT, amount);
    write_reg(REG_TRED, tr);
    write_reg(REG_TGREEN, tg);
    write_reg(REG_TBLUE, tb);
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_TBLUE + 1, REG_LAST_IDX)), 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] mode_byte;
    logic [7:0] amount;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    int         phase_len;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: each adjustment at its extremes, then the undecoded modes
    apply_setting({5'd0, MODE_BRIGHT}, 8'(-100), 8'd0, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd1, 8'd254);
    apply_setting({5'd0, MODE_BRIGHT}, 8'd100, 8'd0, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd200, 8'd55, 8'd255);
    // saturation: push away, then full desaturate, incl. tied channels
    apply_setting({5'd0, MODE_SAT}, 8'd100, 8'd0, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd10, 8'd10, 8'd10);
    apply_setting({5'd0, MODE_SAT}, 8'(-100), 8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd128, 8'd0);
    send_pixel(8'd60, 8'd200, 8'd200);
    // vibrance, then an amount beyond the nominal range
    apply_setting({5'd0, MODE_VIBRANCE}, 8'(-100), 8'd0, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd40, 8'd200, 8'd120);
    apply_setting({5'd0, MODE_VIBRANCE}, 8'd127, 8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd1, 8'd2, 8'd3);
    // greyscale ignores amount
    apply_setting({5'd0, MODE_GREY}, 8'd127, 8'd9, 8'd9, 8'd9);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd77, 8'd150, 8'd29);
    // contrast at the most negative amount and at full gain
    apply_setting({5'd0, MODE_CONTRAST}, 8'(-128), 8'd0, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd127, 8'd128);
    apply_setting({5'd0, MODE_CONTRAST}, 8'd100, 8'd0, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd127, 8'd128);
    send_pixel(8'd255, 8'd200, 8'd55);
    // colorize toward and away from a target, channels on both sides of it
    apply_setting({5'd0, MODE_COLOR}, 8'd100, 8'd0, 8'd255, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd128);
    send_pixel(8'd10, 8'd240, 8'd64);
    apply_setting({5'd0, MODE_COLOR}, 8'(-100), 8'd255, 8'd0, 8'd37);
    send_pixel(8'd0, 8'd255, 8'd200);
    // undecoded modes, written with junk in the upper data bits
    apply_setting({5'b10110, MODE_SPARE_LO}, 8'd50, 8'd0, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd2, 8'd3);
    apply_setting({5'b11111, MODE_SPARE_HI}, 8'(-50), 8'd0, 8'd0, 8'd255);
    send_pixel(8'd254, 8'd253, 8'd252);

    // Random phases: fresh setting, then a burst of pixels
    while (pixels_sent < PIXEL_BUDGET) begin
      idle_style = idle_style_t'($urandom_range(0, 2));
      if ($urandom_range(0, 9) == 0) mode_byte = 8'($urandom);
      else mode_byte = {5'($urandom), 3'($urandom_range(MODE_BRIGHT, MODE_COLOR))};
      case ($urandom_range(0, 9))
        0: amount = 8'(-100);
        1: amount = 8'd100;
        2: amount = 8'h80;
        3: amount = 8'h7f;
        4: amount = 8'd0;
        5: amount = 8'($urandom);
        default: amount = 8'(int'($urandom_range(0, 200)) - 100);
      endcase
      if ($urandom_range(0, 3) == 0)
        apply_setting(mode_byte, amount, {8{1'($urandom)}}, {8{1'($urandom)}},
                      {8{1'($urandom)}});
      else
        apply_setting(mode_byte, amount, 8'($urandom), 8'($urandom), 8'($urandom));

      idle_style = idle_style_t'($urandom_range(0, 2));
      phase_len  = $urandom_range(10, 70);
      repeat (phase_len) begin
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        case ($urandom_range(0, 9))
          // grey pixel: every channel is the max
          0: begin
            g = r;
            b = r;
          end
          // two channels tied
          1: g = r;
          2: begin
            r = 8'd255;
            b = 8'd0;
          end
          // each channel at an end of its range
          3: begin
            r = {8{r[0]}};
            g = {8{g[0]}};
            b = {8{b[0]}};
          end
          default: ;
        endcase
        send_pixel(r, g, b);
      end
    end

    settle();
    if (fail_count == 0)
      $display("** rgb_color_adjust: PASSED **");
    else
      $display("** rgb_color_adjust: FAILED **");
    $finish;
  end

endmodule
